// ----- hw/rtl/polygon_orientation_bbox_assert.svh -----
// ----------------------------------------------------------------------------
// Polygon orientation and bounding box: assertion macros
// Shared concurrent assertion forms used by the tracker and orientation modules.
// ----------------------------------------------------------------------------
`ifndef POLYGON_ORIENTATION_BBOX_ASSERT_SVH
`define POLYGON_ORIENTATION_BBOX_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define POB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pob assertion failed");

// Next-cycle implication, disabled while reset is high.
`define POB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pob assertion failed");

`endif

// ----- hw/rtl/pob_pkg.sv -----
// ----------------------------------------------------------------------------
// Polygon orientation and bounding box: package
// Payload types of the vertex and result channels and internal stage types.
// ----------------------------------------------------------------------------
package pob_pkg;

   // Width of every coordinate field on the ports.
   localparam int FIELD_WIDTH = 16;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] coord_x;
      logic signed [FIELD_WIDTH-1:0] coord_y;
      logic                          final_vertex;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] min_x;
      logic signed [FIELD_WIDTH-1:0] max_x;
      logic signed [FIELD_WIDTH-1:0] min_y;
      logic signed [FIELD_WIDTH-1:0] max_y;
   } box_type;

   typedef struct packed {
      logic                          is_clockwise;
      logic                          enough_points;
      logic signed [FIELD_WIDTH-1:0] min_x;
      logic signed [FIELD_WIDTH-1:0] max_x;
      logic signed [FIELD_WIDTH-1:0] min_y;
      logic signed [FIELD_WIDTH-1:0] max_y;
   } rsp_type;

   // Status that travels with a finished polygon down the orientation pipe.
   typedef struct packed {
      logic valid;
      logic enough;
   } stage_ctl_type;

endpackage

// ----- hw/rtl/pob_tracker.sv -----
// ----------------------------------------------------------------------------
// Polygon orientation and bounding box: vertex tracker
// Running box, lowest vertex and its ring neighbours; on the closing vertex
// it registers the edge vectors around the lowest vertex and the box.
// ----------------------------------------------------------------------------
`include "polygon_orientation_bbox_assert.svh"

module pob_tracker #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          vtx_valid,
   input  pob_pkg::req_type              vtx,
   input  logic                          down_ready,
   output logic                          vtx_take,
   output pob_pkg::stage_ctl_type        ctl_out,
   output logic signed [COORD_WIDTH:0]   prev_dx,
   output logic signed [COORD_WIDTH:0]   prev_dy,
   output logic signed [COORD_WIDTH:0]   succ_dx,
   output logic signed [COORD_WIDTH:0]   succ_dy,
   output pob_pkg::box_type              box_out
);
   import pob_pkg::*;

   localparam logic [1:0] SEEN_FULL = 2'd3;

   logic signed [COORD_WIDTH-1:0] vx, vy;

   // Control state.
   logic [1:0] seen_ff, seen_in;
   logic       pending_ff, pending_in;
   logic       is_first_ff, is_first_in;

   // Vertex state.
   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, first_x_in, first_y_in;
   logic signed [COORD_WIDTH-1:0] last_x_ff, last_y_ff;
   logic signed [COORD_WIDTH-1:0] ext_x_ff, ext_y_ff, ext_x_in, ext_y_in;
   logic signed [COORD_WIDTH-1:0] eprv_x_ff, eprv_y_ff, eprv_x_in, eprv_y_in;
   logic signed [COORD_WIDTH-1:0] esuc_x_ff, esuc_y_ff, esuc_x_in, esuc_y_in;
   logic signed [COORD_WIDTH-1:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic signed [COORD_WIDTH-1:0] lo_x_in, hi_x_in, lo_y_in, hi_y_in;

   // Neighbours used for the cross product.
   logic signed [COORD_WIDTH-1:0] p_x, p_y, n_x, n_y;

   // Stage register toward the orientation pipe.
   logic                        s1_valid_ff, s1_valid_in, s1_ready;
   logic                        s1_enough_ff;
   logic signed [COORD_WIDTH:0] pdx_ff, pdy_ff, ndx_ff, ndy_ff;
   box_type                     box_ff, box_in;

   logic seen_zero, replace, closing;

   always_comb begin
      vx = COORD_WIDTH'(unsigned'(vtx.coord_x));
      vy = COORD_WIDTH'(unsigned'(vtx.coord_y));
      seen_zero = (seen_ff == 2'd0);
      replace = !seen_zero &&
                ((vy < ext_y_ff) || ((vy == ext_y_ff) && (vx == ext_x_ff)));

      seen_in     = (seen_ff == SEEN_FULL) ? seen_ff : seen_ff + 2'd1;
      pending_in  = seen_zero || replace;
      is_first_in = seen_zero ? 1'b1 : (replace ? 1'b0 : is_first_ff);

      first_x_in = seen_zero ? vx : first_x_ff;
      first_y_in = seen_zero ? vy : first_y_ff;
      ext_x_in   = (seen_zero || replace) ? vx : ext_x_ff;
      ext_y_in   = (seen_zero || replace) ? vy : ext_y_ff;
      eprv_x_in  = replace ? last_x_ff : eprv_x_ff;
      eprv_y_in  = replace ? last_y_ff : eprv_y_ff;
      esuc_x_in  = (!seen_zero && pending_ff) ? vx : esuc_x_ff;
      esuc_y_in  = (!seen_zero && pending_ff) ? vy : esuc_y_ff;

      lo_x_in = (seen_zero || vx < lo_x_ff) ? vx : lo_x_ff;
      hi_x_in = (seen_zero || vx > hi_x_ff) ? vx : hi_x_ff;
      lo_y_in = (seen_zero || vy < lo_y_ff) ? vy : lo_y_ff;
      hi_y_in = (seen_zero || vy > hi_y_ff) ? vy : hi_y_ff;

      // The ring wraps: a first-vertex extreme takes the closing vertex as
      // its predecessor, and an extreme without successor takes the first.
      p_x = is_first_in ? vx : eprv_x_in;
      p_y = is_first_in ? vy : eprv_y_in;
      n_x = pending_in ? first_x_in : esuc_x_in;
      n_y = pending_in ? first_y_in : esuc_y_in;

      box_in.min_x = FIELD_WIDTH'(unsigned'(lo_x_in));
      box_in.max_x = FIELD_WIDTH'(unsigned'(hi_x_in));
      box_in.min_y = FIELD_WIDTH'(unsigned'(lo_y_in));
      box_in.max_y = FIELD_WIDTH'(unsigned'(hi_y_in));

      s1_ready    = !s1_valid_ff || down_ready;
      vtx_take    = vtx_valid && (!vtx.final_vertex || s1_ready);
      closing     = vtx_take && vtx.final_vertex;
      s1_valid_in = s1_ready ? closing : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 2'd0;
         pending_ff  <= 1'b0;
         is_first_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (closing) begin
            seen_ff     <= 2'd0;
            pending_ff  <= 1'b0;
            is_first_ff <= 1'b1;
         end else if (vtx_take) begin
            seen_ff     <= seen_in;
            pending_ff  <= pending_in;
            is_first_ff <= is_first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vtx_take) begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         last_x_ff  <= vx;
         last_y_ff  <= vy;
         ext_x_ff   <= ext_x_in;
         ext_y_ff   <= ext_y_in;
         eprv_x_ff  <= eprv_x_in;
         eprv_y_ff  <= eprv_y_in;
         esuc_x_ff  <= esuc_x_in;
         esuc_y_ff  <= esuc_y_in;
         lo_x_ff    <= lo_x_in;
         hi_x_ff    <= hi_x_in;
         lo_y_ff    <= lo_y_in;
         hi_y_ff    <= hi_y_in;
      end
      if (closing) begin
         s1_enough_ff <= (seen_in == SEEN_FULL);
         pdx_ff <= (COORD_WIDTH+1)'(p_x) - (COORD_WIDTH+1)'(ext_x_in);
         pdy_ff <= (COORD_WIDTH+1)'(p_y) - (COORD_WIDTH+1)'(ext_y_in);
         ndx_ff <= (COORD_WIDTH+1)'(n_x) - (COORD_WIDTH+1)'(ext_x_in);
         ndy_ff <= (COORD_WIDTH+1)'(n_y) - (COORD_WIDTH+1)'(ext_y_in);
         box_ff <= box_in;
      end
   end

   assign ctl_out.valid  = s1_valid_ff;
   assign ctl_out.enough = s1_enough_ff;
   assign prev_dx = pdx_ff;
   assign prev_dy = pdy_ff;
   assign succ_dx = ndx_ff;
   assign succ_dy = ndy_ff;
   assign box_out = box_ff;

   `POB_ASSERT_NEXT(a_close_clears, clock, reset, closing,
                    (seen_ff == 2'd0) && is_first_ff && !pending_ff && s1_valid_ff)
   `POB_ASSERT_NOW(a_box_ordered, clock, reset, seen_ff != 2'd0,
                   (lo_x_ff <= hi_x_ff) && (lo_y_ff <= hi_y_ff))
   `POB_ASSERT_NEXT(a_stage_held, clock, reset, s1_valid_ff && !down_ready, s1_valid_ff)
endmodule

// ----- hw/rtl/pob_orient.sv -----
// ----------------------------------------------------------------------------
// Polygon orientation and bounding box: orientation stage
// Two registered cross-product terms, then the sign test into the result
// register.
// ----------------------------------------------------------------------------
`include "polygon_orientation_bbox_assert.svh"

module pob_orient #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pob_pkg::stage_ctl_type      ctl_in,
   input  logic signed [COORD_WIDTH:0] prev_dx,
   input  logic signed [COORD_WIDTH:0] prev_dy,
   input  logic signed [COORD_WIDTH:0] succ_dx,
   input  logic signed [COORD_WIDTH:0] succ_dy,
   input  pob_pkg::box_type            box_in,
   output logic                        up_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pob_pkg::rsp_type            rsp
);
   import pob_pkg::*;

   localparam int PROD_WIDTH = 2 * COORD_WIDTH + 2;

   logic                         s2_valid_ff, s2_valid_in, s2_ready;
   logic                         s2_enough_ff;
   box_type                      s2_box_ff;
   logic signed [PROD_WIDTH-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic                         out_valid_ff, out_valid_in, out_ready;
   rsp_type                      out_ff, out_in;

   always_comb begin
      p1_in = PROD_WIDTH'(prev_dx) * PROD_WIDTH'(succ_dy);
      p2_in = PROD_WIDTH'(succ_dx) * PROD_WIDTH'(prev_dy);

      out_ready   = !out_valid_ff || !rsp_stall;
      s2_ready    = !s2_valid_ff || out_ready;
      s2_valid_in = s2_ready ? ctl_in.valid : s2_valid_ff;
      out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

      // A zero cross product counts as counter-clockwise.
      out_in.is_clockwise  = s2_enough_ff && (p1_ff < p2_ff);
      out_in.enough_points = s2_enough_ff;
      out_in.min_x = s2_box_ff.min_x;
      out_in.max_x = s2_box_ff.max_x;
      out_in.min_y = s2_box_ff.min_y;
      out_in.max_y = s2_box_ff.max_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && ctl_in.valid) begin
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         s2_enough_ff <= ctl_in.enough;
         s2_box_ff    <= box_in;
      end
      if (out_ready && s2_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign up_ready  = s2_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   `POB_ASSERT_NOW(a_cw_needs_points, clock, reset, out_valid_ff,
                   !out_ff.is_clockwise || out_ff.enough_points)
   `POB_ASSERT_NEXT(a_s2_moves, clock, reset, s2_valid_ff && out_ready, out_valid_ff)
   `POB_ASSERT_NEXT(a_s2_held, clock, reset, s2_valid_ff && !out_ready, s2_valid_ff)
endmodule

// ----- hw/rtl/polygon_orientation_bbox.sv -----
// ----------------------------------------------------------------------------
// Polygon orientation and bounding box: top level
// Streams polygon vertices and reports each polygon's box and winding.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat
//   req_      in         req_valid / req_stall  one vertex with closing flag
//   rsp_      out        rsp_valid / rsp_stall  box and orientation of a polygon
//
// One vertex beat can be taken in every cycle unless a closing vertex waits
// for room in a stalled pipe. Once accepted into the input register, a closing
// vertex passes the tracker stage, the product stage and the result register
// before its result shows on rsp_valid. Reset is synchronous and clears only
// control state. A stalled result backs up the product and tracker stages
// first; ordinary vertices keep flowing until a closing vertex finds no room.
//
// The tracker folds every vertex into the running box and keeps the lowest
// vertex together with its predecessor and successor on the ring. When the
// closing vertex arrives the edge vectors out of the lowest vertex are
// registered, the next stage forms the two cross-product terms, and the last
// stage compares them. A negative cross product reports clockwise; polygons
// with fewer than three vertices report not clockwise and clear
// enough_points. The tracker returns to its empty state after each polygon.
// ----------------------------------------------------------------------------
module polygon_orientation_bbox #(
   parameter int COORD_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pob_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pob_pkg::rsp_type rsp
);
   import pob_pkg::*;

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    in_take;

   stage_ctl_type               trk_ctl;
   logic signed [COORD_WIDTH:0] prev_dx, prev_dy, succ_dx, succ_dy;
   box_type                     trk_box;
   logic                        orient_ready;

   // The input register refills whenever its beat leaves or it is empty.
   always_comb begin
      req_stall   = in_valid_ff && !in_take;
      in_valid_in = req_stall ? in_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_ff <= req;
      end
   end

   pob_tracker #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .vtx_valid  (in_valid_ff),
      .vtx        (in_ff),
      .down_ready (orient_ready),
      .vtx_take   (in_take),
      .ctl_out    (trk_ctl),
      .prev_dx    (prev_dx),
      .prev_dy    (prev_dy),
      .succ_dx    (succ_dx),
      .succ_dy    (succ_dy),
      .box_out    (trk_box)
   );

   pob_orient #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_orient (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (trk_ctl),
      .prev_dx   (prev_dx),
      .prev_dy   (prev_dy),
      .succ_dx   (succ_dx),
      .succ_dy   (succ_dy),
      .box_in    (trk_box),
      .up_ready  (orient_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );
endmodule
